[rtl/core/gwm_pkg.sv]
`default_nettype none

package gwm_pkg;

   localparam int PATTERN_DEPTH_DEF = 32;

   localparam logic [7:0] STAR_BYTE  = 8'h2A;
   localparam logic [7:0] QMARK_BYTE = 8'h3F;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_CLEAR   = 2'd0;
   localparam cmd_type CMD_APPEND  = 2'd1;
   localparam cmd_type CMD_SUBJECT = 2'd2;
   localparam cmd_type CMD_END     = 2'd3;

   // decoded transaction handed from front to back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_byte;
      logic       is_star;
      logic       is_qmark;
   } op_type;

endpackage

`default_nettype wire

[rtl/core/gwm_front.sv]
`default_nettype none

module gwm_front
   import gwm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_data_byte,
   output logic            q_valid,
   input  wire logic       q_ready,
   output op_type          q_op
);

   op_type     ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   op_type     op_dec;
   logic       push, pop;

   always_comb begin
      op_dec.cmd       = req_command;
      op_dec.data_byte = req_data_byte;
      op_dec.is_star   = (req_data_byte == STAR_BYTE);
      op_dec.is_qmark  = (req_data_byte == QMARK_BYTE);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_op      = ent_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= op_dec;
      end
   end

endmodule

`default_nettype wire

[rtl/core/gwm_back.sv]
`default_nettype none

module gwm_back
   import gwm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_valid,
   output logic        q_ready,
   input  wire op_type q_op,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output logic        rsp_matched,
   output logic        rsp_pattern_overflow
);

   localparam int CW = $clog2(PATTERN_DEPTH + 1);
   localparam int NP = PATTERN_DEPTH + 1;

   logic [7:0]    byte_ff  [PATTERN_DEPTH];
   logic          star_ff  [PATTERN_DEPTH];
   logic          qmark_ff [PATTERN_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [NP-1:0] active_ff, active_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          matched_ff, matched_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          take;
   logic          full;
   logic [NP-1:0] in_pat;
   logic [NP-1:0] prop;
   logic [NP:0]   sum;
   logic [NP-1:0] closed;
   logic [NP-1:0] next_set;

   assign q_ready = (q_op.cmd != CMD_END) || !rsp_valid_ff || rsp_ready;
   assign take    = q_valid && q_ready;
   assign full    = (count_ff == CW'(PATTERN_DEPTH));

   // star closure as a carry ripple: a seed carries up through positions
   // that follow a stored star
   always_comb begin
      in_pat = '0;
      prop   = '0;
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
         in_pat[p]   = (CW'(p) < count_ff);
         prop[p + 1] = star_ff[p] && (CW'(p) < count_ff);
      end
      sum    = {1'b0, active_ff | prop} + {1'b0, active_ff};
      closed = active_ff | ((active_ff | prop) & ~sum[NP-1:0]);
   end

   always_comb begin
      next_set = '0;
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
         if (closed[p] && in_pat[p]) begin
            if (star_ff[p]) begin
               next_set[p] = 1'b1;
            end else if (qmark_ff[p] || (byte_ff[p] == q_op.data_byte)) begin
               next_set[p + 1] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      matched_in   = matched_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (take) begin
         case (q_op.cmd)
            CMD_CLEAR: begin
               count_in  = '0;
               ovf_in    = 1'b0;
               active_in = NP'(1);
            end
            CMD_APPEND: begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_SUBJECT: begin
               active_in = next_set;
            end
            CMD_END: begin
               rsp_valid_in = 1'b1;
               matched_in   = closed[count_ff] && !ovf_ff;
               rsp_ovf_in   = ovf_ff;
               active_in    = NP'(1);
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         active_ff    <= NP'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
         if (take && (q_op.cmd == CMD_APPEND) && (count_ff == CW'(p))) begin
            byte_ff[p]  <= q_op.data_byte;
            star_ff[p]  <= q_op.is_star;
            qmark_ff[p] <= q_op.is_qmark;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

[rtl/core/glob_wildcard_match.sv]
// Glob matcher for '*' and '?' patterns against a streamed subject.
// Request channel (req_valid/req_ready): req_command selects clear pattern,
// append pattern byte (req_data_byte), subject byte (req_data_byte) or end
// of subject. Only an end-of-subject transaction produces a response.
// Response channel (rsp_valid/rsp_ready): rsp_matched is 1 when the whole
// subject matched; rsp_pattern_overflow flags a pattern longer than
// PATTERN_DEPTH bytes, with rsp_matched forced to 0.
// Throughput: one request per cycle, sustained while no end-of-subject waits on a
// held response. A two-entry queue sits between the decode front and the
// match engine; the engine updates the whole active-position set, star
// closure included, per subject byte. The end-of-subject transaction passes
// through the queue; its verdict is registered in the output register.
// If the receiver stalls, the response is held in the output register and
// non-end requests keep flowing; a second end waits in the queue, and
// req_ready drops once the queue is full.
// Reset: empty pattern, no overflow, active set back to position zero,
// queue and response register empty. Pattern bytes need no clearing.

`default_nettype none

module glob_wildcard_match
   import gwm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   logic   q_valid;
   logic   q_ready;
   op_type q_op;

   gwm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_op          (q_op)
   );

   gwm_back #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_ready              (q_ready),
      .q_op                 (q_op),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow)
   );

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gwm_pkg::*;

   localparam int DEPTH           = PATTERN_DEPTH_DEF;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int PHASE_ITEMS     = 90;

   localparam logic [7:0] LETTER_A = 8'h61;
   localparam logic [7:0] LETTER_B = 8'h62;
   localparam logic [7:0] LETTER_X = 8'h78;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   typedef logic [7:0] byte_q_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = CMD_CLEAR;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_overflow;

   glob_wildcard_match #(
      .PATTERN_DEPTH(DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_matched         (rsp_matched),
      .rsp_pattern_overflow(rsp_pattern_overflow)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Matcher prediction: pattern store plus active-position set
   // ---------------------------------------------------------------
   logic [7:0]     glob_bytes [DEPTH];
   int             glob_len = 0;
   logic           glob_overflow = 1'b0;
   logic [DEPTH:0] live_set = 1;
   verdict_type    pending_verdicts[$];

   int items_issued = 0;
   int failures = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;
   verdict_type got_verdict;

   // positions sitting on a star also reach the next position, chained
   function automatic logic [DEPTH:0] star_closed(input logic [DEPTH:0] s);
      int p;
      for (p = 0; p < glob_len; p++)
         if (s[p] && glob_bytes[p] == STAR_BYTE) s[p + 1] = 1'b1;
      return s;
   endfunction

   function automatic void predict_glob_step(input cmd_type cmd, input logic [7:0] b);
      logic [DEPTH:0] cur;
      logic [DEPTH:0] nxt;
      verdict_type v;
      int p;
      case (cmd)
         CMD_CLEAR: begin
            glob_len = 0;
            glob_overflow = 1'b0;
            live_set = 1;
         end
         CMD_APPEND: begin
            if (glob_len < DEPTH) begin
               glob_bytes[glob_len] = b;
               glob_len++;
            end else begin
               glob_overflow = 1'b1;
            end
         end
         CMD_SUBJECT: begin
            cur = star_closed(live_set);
            nxt = '0;
            for (p = 0; p < glob_len; p++) begin
               if (cur[p]) begin
                  if (glob_bytes[p] == STAR_BYTE) nxt[p] = 1'b1;
                  else if (glob_bytes[p] == QMARK_BYTE || glob_bytes[p] == b) nxt[p + 1] = 1'b1;
               end
            end
            live_set = nxt;
         end
         CMD_END: begin
            cur = star_closed(live_set);
            v.matched = cur[glob_len] && !glob_overflow;
            v.overflow = glob_overflow;
            pending_verdicts.push_back(v);
            live_set = 1;
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   task automatic issue_request(input cmd_type cmd, input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_glob_step(cmd, b);
      items_issued++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   function automatic logic [7:0] glob_symbol();
      case ($urandom_range(9))
         0, 1:    return STAR_BYTE;
         2:       return QMARK_BYTE;
         3, 4, 5: return LETTER_A;
         6, 7:    return LETTER_B;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] subject_symbol();
      case ($urandom_range(4))
         0, 1:    return LETTER_A;
         2:       return LETTER_B;
         default: return 8'($urandom);
      endcase
   endfunction

   // a subject that the given pattern accepts
   function automatic byte_q_type matching_subject(input byte_q_type pat);
      byte_q_type s;
      foreach (pat[i]) begin
         if (pat[i] == STAR_BYTE) repeat ($urandom_range(3)) s.push_back(subject_symbol());
         else if (pat[i] == QMARK_BYTE) s.push_back(8'($urandom));
         else s.push_back(pat[i]);
      end
      return s;
   endfunction

   task automatic load_glob(input byte_q_type pat);
      issue_request(CMD_CLEAR, 8'($urandom));
      foreach (pat[i]) issue_request(CMD_APPEND, pat[i]);
   endtask

   // now and then the pattern grows while a subject is in flight
   task automatic feed_subject(input byte_q_type subj);
      foreach (subj[i]) begin
         if ($urandom_range(49) == 0) issue_request(CMD_APPEND, glob_symbol());
         issue_request(CMD_SUBJECT, subj[i]);
      end
      issue_request(CMD_END, 8'($urandom));
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_empty_pattern();
      issue_request(CMD_CLEAR, 8'h00);
      issue_request(CMD_END, 8'h00);
      issue_request(CMD_SUBJECT, 8'h00);
      issue_request(CMD_END, 8'hFF);
   endtask

   // zero byte is a literal; star eats 0xFF, question mark eats one byte
   task automatic test_literals_and_wildcards();
      issue_request(CMD_CLEAR, 8'hFF);
      issue_request(CMD_APPEND, 8'h00);
      issue_request(CMD_APPEND, STAR_BYTE);
      issue_request(CMD_APPEND, QMARK_BYTE);
      issue_request(CMD_SUBJECT, 8'h00);
      issue_request(CMD_SUBJECT, 8'hFF);
      issue_request(CMD_SUBJECT, LETTER_A);
      issue_request(CMD_END, 8'h00);
      issue_request(CMD_SUBJECT, 8'h00);
      issue_request(CMD_END, 8'hFF);
   endtask

   task automatic test_edit_mid_subject();
      issue_request(CMD_CLEAR, 8'h00);
      issue_request(CMD_APPEND, LETTER_X);
      issue_request(CMD_SUBJECT, LETTER_X);
      issue_request(CMD_APPEND, 8'hFF);
      issue_request(CMD_SUBJECT, 8'hFF);
      issue_request(CMD_END, 8'h00);
   endtask

   // full store must still match; past the store the flag sticks until clear
   task automatic test_pattern_overflow();
      byte_q_type pat;
      repeat (DEPTH) pat.push_back(glob_symbol());
      load_glob(pat);
      feed_subject(matching_subject(pat));
      repeat ($urandom_range(4, 1)) issue_request(CMD_APPEND, 8'($urandom));
      feed_subject(matching_subject(pat));
      issue_request(CMD_END, 8'hFF);
      issue_request(CMD_CLEAR, 8'hFF);
      issue_request(CMD_END, 8'h00);
   endtask

   // receiver goes quiet while end transactions keep coming, so the queue fills
   task automatic test_response_hold_off();
      wait_for_drain();
      issue_request(CMD_CLEAR, 8'h00);
      issue_request(CMD_APPEND, STAR_BYTE);
      issue_request(CMD_APPEND, LETTER_A);
      hold_off_requests++;
      repeat (8) begin
         issue_request(CMD_SUBJECT, subject_symbol());
         issue_request(CMD_END, 8'($urandom));
      end
      wait_for_drain();
   endtask

   task automatic run_random_globs(input int item_goal);
      byte_q_type pat;
      byte_q_type subj;
      int n;
      while (items_issued < item_goal) begin
         if ($urandom_range(9) == 0) begin
            issue_request(cmd_type'($urandom_range(3)), 8'($urandom));
            continue;
         end
         pat = {};
         n = ($urandom_range(19) == 0) ? $urandom_range(DEPTH, 7) : $urandom_range(6);
         repeat (n) pat.push_back(glob_symbol());
         // sometimes extend whatever pattern is already loaded
         if ($urandom_range(7) != 0) issue_request(CMD_CLEAR, 8'($urandom));
         foreach (pat[i]) issue_request(CMD_APPEND, pat[i]);
         repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(9) < 6) begin
               subj = matching_subject(pat);
               if ($urandom_range(3) == 0) begin
                  if (subj.size() == 0) subj.push_back(subject_symbol());
                  else subj[$urandom_range(subj.size() - 1)] = subject_symbol();
               end
            end else begin
               subj = {};
               repeat ($urandom_range(6)) subj.push_back(subject_symbol());
            end
            feed_subject(subj);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Response side: ready generation, checking, watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with none pending: matched=%0b pattern_overflow=%0b",
                   rsp_matched, rsp_pattern_overflow);
            failures++;
         end else begin
            got_verdict = pending_verdicts.pop_front();
            if (rsp_matched !== got_verdict.matched) begin
               $error("rsp_matched: expected %0b, got %0b", got_verdict.matched, rsp_matched);
               failures++;
            end
            if (rsp_pattern_overflow !== got_verdict.overflow) begin
               $error("rsp_pattern_overflow: expected %0b, got %0b",
                      got_verdict.overflow, rsp_pattern_overflow);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $error("no transaction for %0d cycles, %0d responses pending",
                WATCHDOG_LIMIT, pending_verdicts.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_empty_pattern();
      test_literals_and_wildcards();
      test_edit_mid_subject();
      test_pattern_overflow();
      test_response_hold_off();

      run_random_globs(items_issued + PHASE_ITEMS);
      wait_for_drain();
      set_idling(61, 0);
      run_random_globs(items_issued + PHASE_ITEMS);
      wait_for_drain();
      set_idling(0, 61);
      run_random_globs(items_issued + PHASE_ITEMS);
      wait_for_drain();
      set_idling(34, 34);
      run_random_globs(items_issued + PHASE_ITEMS);
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
